[src/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ISG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Property checked at every clock edge, reset included.
`define ISG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[src/isg_pkg.sv]
// Package: lattice geometry, field widths, register indexes and shared types.
`default_nettype none
package isg_pkg;

  localparam int ROWS    = 64;
  localparam int COLUMNS = 64;
  localparam int RowW    = $clog2(ROWS);
  localparam int ColW    = $clog2(COLUMNS);

  localparam int RowInW  = 6;
  localparam int ColInW  = 6;
  localparam int ThrW    = 14;
  localparam int BondW   = 15;
  localparam int MagW    = 14;
  localparam int CfgIdxW = 1;

  typedef logic [RowW-1:0]     row_t;
  typedef logic [ColW-1:0]     col_t;
  typedef logic [COLUMNS-1:0]  word_t;
  typedef logic [ThrW-1:0]     thr_t;
  typedef logic signed [BondW-1:0] bond_t;
  typedef logic signed [MagW-1:0]  mag_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;

  localparam cfg_idx_t CFG_RISE_FOUR  = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_RISE_EIGHT = cfg_idx_t'(1);

  localparam bond_t BOND_RESET = bond_t'(2 * ROWS * COLUMNS);
  localparam mag_t  MAG_RESET  = mag_t'(ROWS * COLUMNS);

  // Outcome of one site update, from the decision logic to the top level.
  typedef struct packed {
    logic              change;    // site spin changes value
    logic              flipped;   // attempt accepted
    logic              new_spin;
    logic signed [4:0] bond_step; // bond sum correction, -8..8
    logic signed [2:0] mag_step;  // magnetisation correction, -2..2
    word_t             new_word;  // centre row with the site rewritten
  } decide_t;

endpackage
`default_nettype wire

[src/isg_ram.sv]
// Generic single-write, single-read RAM with registered, read-first output.
`default_nettype none
module isg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[src/isg_lattice.sv]
// Spin lattice store: three row copies, row valid bits and write forwarding.
`default_nettype none
module isg_lattice (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire isg_pkg::row_t rd_row_i,
  input  wire logic          wr_en_i,
  input  wire isg_pkg::row_t wr_row_i,
  input  wire isg_pkg::word_t wr_word_i,
  output isg_pkg::word_t     up_word_o,
  output isg_pkg::word_t     mid_word_o,
  output isg_pkg::word_t     dn_word_o
);

  isg_pkg::row_t  up_row, dn_row;
  isg_pkg::row_t  up_row_q, mid_row_q, dn_row_q;
  isg_pkg::word_t up_raw, mid_raw, dn_raw;
  logic           row_valid_q [isg_pkg::ROWS];
  logic           fwd_en_q;
  isg_pkg::row_t  fwd_row_q;
  isg_pkg::word_t fwd_word_q;

  // toroidal neighbours
  assign up_row = (rd_row_i == '0) ? isg_pkg::row_t'(isg_pkg::ROWS - 1)
                                   : rd_row_i - 1'b1;
  assign dn_row = (rd_row_i == isg_pkg::row_t'(isg_pkg::ROWS - 1)) ? '0
                                   : rd_row_i + 1'b1;

  isg_ram #(.Width(isg_pkg::COLUMNS), .Depth(isg_pkg::ROWS)) u_ram_up (
    .clk_i, .we_i(wr_en_i), .waddr_i(wr_row_i), .wdata_i(wr_word_i),
    .re_i(rd_en_i), .raddr_i(up_row), .rdata_o(up_raw)
  );
  isg_ram #(.Width(isg_pkg::COLUMNS), .Depth(isg_pkg::ROWS)) u_ram_mid (
    .clk_i, .we_i(wr_en_i), .waddr_i(wr_row_i), .wdata_i(wr_word_i),
    .re_i(rd_en_i), .raddr_i(rd_row_i), .rdata_o(mid_raw)
  );
  isg_ram #(.Width(isg_pkg::COLUMNS), .Depth(isg_pkg::ROWS)) u_ram_dn (
    .clk_i, .we_i(wr_en_i), .waddr_i(wr_row_i), .wdata_i(wr_word_i),
    .re_i(rd_en_i), .raddr_i(dn_row), .rdata_o(dn_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < isg_pkg::ROWS; i++) begin
        row_valid_q[i] <= 1'b0;
      end
      fwd_en_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_row_i] <= 1'b1;
      end
      fwd_en_q <= wr_en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_row_q  <= up_row;
      mid_row_q <= rd_row_i;
      dn_row_q  <= dn_row;
    end
    if (wr_en_i) begin
      fwd_row_q  <= wr_row_i;
      fwd_word_q <= wr_word_i;
    end
  end

  // A row written at the read edge comes from the forward register (RAM gave
  // old data); a row never written reads as all spins up.
  function automatic isg_pkg::word_t pick(input isg_pkg::row_t  row,
                                          input isg_pkg::word_t raw,
                                          input logic           fwd_en,
                                          input isg_pkg::row_t  fwd_row,
                                          input isg_pkg::word_t fwd_word,
                                          input logic           valid);
    isg_pkg::word_t w;
    if (fwd_en && (row == fwd_row)) begin
      w = fwd_word;
    end else if (valid) begin
      w = raw;
    end else begin
      w = '1;
    end
    return w;
  endfunction

  assign up_word_o  = pick(up_row_q, up_raw, fwd_en_q, fwd_row_q, fwd_word_q,
                           row_valid_q[up_row_q]);
  assign mid_word_o = pick(mid_row_q, mid_raw, fwd_en_q, fwd_row_q, fwd_word_q,
                           row_valid_q[mid_row_q]);
  assign dn_word_o  = pick(dn_row_q, dn_raw, fwd_en_q, fwd_row_q, fwd_word_q,
                           row_valid_q[dn_row_q]);

endmodule
`default_nettype wire

[src/isg_decide.sv]
// Site update decision: neighbour count, Metropolis acceptance, sum corrections.
`default_nettype none
module isg_decide (
  input  wire logic           action_i,
  input  wire isg_pkg::col_t  col_i,
  input  wire logic           spin_value_i,
  input  wire isg_pkg::thr_t  draw_i,
  input  wire isg_pkg::thr_t  thr_four_i,
  input  wire isg_pkg::thr_t  thr_eight_i,
  input  wire isg_pkg::word_t up_word_i,
  input  wire isg_pkg::word_t mid_word_i,
  input  wire isg_pkg::word_t dn_word_i,
  output isg_pkg::decide_t    dec_o
);

  isg_pkg::col_t     left_col, right_col;
  logic              s, n_up, n_dn, n_left, n_right;
  logic [2:0]        ones, aligned;
  logic              accept;
  logic signed [4:0] twice_n;

  assign left_col  = (col_i == '0) ? isg_pkg::col_t'(isg_pkg::COLUMNS - 1)
                                   : col_i - 1'b1;
  assign right_col = (col_i == isg_pkg::col_t'(isg_pkg::COLUMNS - 1)) ? '0
                                   : col_i + 1'b1;

  assign s       = mid_word_i[col_i];
  assign n_up    = up_word_i[col_i];
  assign n_dn    = dn_word_i[col_i];
  assign n_left  = mid_word_i[left_col];
  assign n_right = mid_word_i[right_col];

  assign ones    = 3'(n_up) + 3'(n_dn) + 3'(n_left) + 3'(n_right);
  // neighbours agreeing with the site; dE = 4*aligned - 8
  assign aligned = s ? ones : 3'(3'd4 - ones);
  // twice the neighbour sum: 4*ones - 8
  assign twice_n = $signed({ones, 2'b00}) - 5'sd8;

  always_comb begin
    case (aligned)
      3'd3:    accept = draw_i < thr_four_i;
      3'd4:    accept = draw_i < thr_eight_i;
      default: accept = 1'b1;
    endcase
  end

  always_comb begin
    dec_o          = '0;
    dec_o.flipped  = action_i & accept;
    dec_o.new_spin = action_i ? (s ^ accept) : spin_value_i;
    dec_o.change   = dec_o.new_spin != s;
    if (dec_o.change) begin
      dec_o.bond_step = dec_o.new_spin ? twice_n : -twice_n;
      dec_o.mag_step  = dec_o.new_spin ? 3'sd2 : -3'sd2;
    end
    dec_o.new_word        = mid_word_i;
    dec_o.new_word[col_i] = dec_o.new_spin;
  end

endmodule
`default_nettype wire

[src/ising_metropolis_spin_update.sv]
// Top level: 2D Ising lattice with single-site loads and Metropolis flip attempts.
// Result path: a transaction accepted at a clock edge is registered in the s1 stage
// (s1_valid_q), then its result is registered in done_q and strobed on done_o.
// Throughput: one transaction per cycle; busy stays low, a row written at the
// same edge as the next read is forwarded. Reset clears the row valid bits,
// so every spin reads +1, sums return to their full-lattice values, thresholds 0.
`default_nettype none
module ising_metropolis_spin_update (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire isg_pkg::cfg_idx_t      cfg_idx_i,
  input  wire isg_pkg::thr_t          cfg_wdata_i,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   action_i,
  input  wire logic [isg_pkg::RowInW-1:0] row_i,
  input  wire logic [isg_pkg::ColInW-1:0] column_i,
  input  wire logic                   spin_value_i,
  input  wire isg_pkg::thr_t          random_draw_i,
  output logic                        done_o,
  output logic                        flipped_o,
  output logic                        spin_after_o,
  output isg_pkg::bond_t              bond_sum_o,
  output isg_pkg::mag_t               magnet_sum_o
);

  logic             accept;
  isg_pkg::row_t    in_row;
  isg_pkg::col_t    in_col;
  logic             s1_valid_q;
  logic             s1_action_q, s1_spin_q;
  isg_pkg::row_t    s1_row_q;
  isg_pkg::col_t    s1_col_q;
  isg_pkg::thr_t    s1_draw_q;
  isg_pkg::thr_t    thr_four_q, thr_eight_q;
  isg_pkg::bond_t   bond_q, bond_d;
  isg_pkg::mag_t    mag_q, mag_d;
  logic             done_q, flipped_q, spin_after_q;
  isg_pkg::word_t   up_word, mid_word, dn_word;
  isg_pkg::decide_t dec;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign in_row = isg_pkg::row_t'(row_i % isg_pkg::ROWS);
  assign in_col = isg_pkg::col_t'(column_i % isg_pkg::COLUMNS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_four_q  <= '0;
      thr_eight_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        isg_pkg::CFG_RISE_FOUR:  thr_four_q  <= cfg_wdata_i;
        isg_pkg::CFG_RISE_EIGHT: thr_eight_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      done_q     <= 1'b0;
      bond_q     <= isg_pkg::BOND_RESET;
      mag_q      <= isg_pkg::MAG_RESET;
    end else begin
      s1_valid_q <= accept;
      done_q     <= s1_valid_q;
      bond_q     <= bond_d;
      mag_q      <= mag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q <= action_i;
      s1_row_q    <= in_row;
      s1_col_q    <= in_col;
      s1_spin_q   <= spin_value_i;
      s1_draw_q   <= random_draw_i;
    end
    if (s1_valid_q) begin
      flipped_q    <= dec.flipped;
      spin_after_q <= dec.new_spin;
    end
  end

  isg_lattice u_lattice (
    .clk_i,
    .rst_ni,
    .rd_en_i   (accept),
    .rd_row_i  (in_row),
    .wr_en_i   (s1_valid_q),
    .wr_row_i  (s1_row_q),
    .wr_word_i (dec.new_word),
    .up_word_o (up_word),
    .mid_word_o(mid_word),
    .dn_word_o (dn_word)
  );

  isg_decide u_decide (
    .action_i    (s1_action_q),
    .col_i       (s1_col_q),
    .spin_value_i(s1_spin_q),
    .draw_i      (s1_draw_q),
    .thr_four_i  (thr_four_q),
    .thr_eight_i (thr_eight_q),
    .up_word_i   (up_word),
    .mid_word_i  (mid_word),
    .dn_word_i   (dn_word),
    .dec_o       (dec)
  );

  always_comb begin
    bond_d = bond_q;
    mag_d  = mag_q;
    if (s1_valid_q) begin
      bond_d = bond_q + isg_pkg::BondW'(dec.bond_step);
      mag_d  = mag_q + isg_pkg::MagW'(dec.mag_step);
    end
  end

  assign done_o       = done_q;
  assign flipped_o    = flipped_q;
  assign spin_after_o = spin_after_q;
  assign bond_sum_o   = bond_q;
  assign magnet_sum_o = mag_q;

endmodule
`default_nettype wire

[src/isg_checker.sv]
// Port-level checker for the Ising spin update block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module isg_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   action_i,
  input wire logic                   done_o,
  input wire logic                   flipped_o,
  input wire isg_pkg::bond_t         bond_sum_o,
  input wire isg_pkg::mag_t          magnet_sum_o
);

  // every accepted transaction is followed by its result on done_o
  `ISG_ASSERT(a_result_latency, start && !busy |-> ##2 done_o, "missing result")
  // no result without an accepted transaction
  `ISG_ASSERT(a_no_spurious, done_o |-> $past(start && !busy, 2), "spurious result")
  // a load never reports a flip
  `ISG_ASSERT(a_load_no_flip, start && !busy && !action_i |-> ##2 !flipped_o, "load flipped")
  // magnetisation stays even, bond sum a multiple of four
  `ISG_ASSERT(a_sum_parity, done_o |-> !magnet_sum_o[0] && bond_sum_o[1:0] == 2'b00, "sum parity")
  // an edge taken in reset clears the strobe, so no result follows it
  `ISG_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> ##1 !done_o, "result during reset")

endmodule

bind ising_metropolis_spin_update isg_checker u_isg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .action_i    (action_i),
  .done_o      (done_o),
  .flipped_o   (flipped_o),
  .bond_sum_o  (bond_sum_o),
  .magnet_sum_o(magnet_sum_o)
);
`default_nettype wire

[tb/ising_metropolis_spin_update_tb.sv]
// Testbench for the Ising spin update block: loads and flip attempts checked against a predictor.
module ising_metropolis_spin_update_tb;
  import isg_pkg::*;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_ATTEMPT = 1'b1;
  localparam int   STALL_LIMIT   = 4000;
  localparam int   RANDOM_PHASES = 6;
  localparam int   PHASE_ITEMS   = 230;

  typedef struct packed {
    logic              action;
    logic [RowInW-1:0] row;
    logic [ColInW-1:0] column;
    logic              spin;
    thr_t              draw;
  } site_op_t;

  typedef struct packed {
    logic  flipped;
    logic  spin_after;
    bond_t bond;
    mag_t  magnet;
  } spin_result_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  cfg_idx_t          cfg_idx_i     = CFG_RISE_FOUR;
  thr_t              cfg_wdata_i   = '0;
  logic              start         = 1'b0;
  logic              busy;
  logic              action_i      = ACT_LOAD;
  logic [RowInW-1:0] row_i         = '0;
  logic [ColInW-1:0] column_i      = '0;
  logic              spin_value_i  = 1'b0;
  thr_t              random_draw_i = '0;
  logic              done_o;
  logic              flipped_o;
  logic              spin_after_o;
  bond_t             bond_sum_o;
  mag_t              magnet_sum_o;

  // Predictor state
  logic         lattice [ROWS][COLUMNS];
  int           bond_total;
  int           magnet_total;
  thr_t         thr_four  = '0;
  thr_t         thr_eight = '0;
  spin_result_t pending_results [$];

  int errors      = 0;
  int idle_cycles = 0;
  bit sending     = 1'b0;
  bit steady      = 1'b0;
  int burst_left  = 0;
  int win_row     = 0;
  int win_col     = 0;

  ising_metropolis_spin_update dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .row_i         (row_i),
    .column_i      (column_i),
    .spin_value_i  (spin_value_i),
    .random_draw_i (random_draw_i),
    .done_o        (done_o),
    .flipped_o     (flipped_o),
    .spin_after_o  (spin_after_o),
    .bond_sum_o    (bond_sum_o),
    .magnet_sum_o  (magnet_sum_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int spin_pm(int r, int c);
    return lattice[r][c] ? 1 : -1;
  endfunction

  // One load or Metropolis step on the predicted lattice.
  function automatic spin_result_t metropolis_step(site_op_t op);
    int r, c, s, ns, nsum, de;
    logic accept;
    spin_result_t res;
    r = int'(op.row) % ROWS;
    c = int'(op.column) % COLUMNS;
    s = spin_pm(r, c);
    nsum = spin_pm((r + ROWS - 1) % ROWS, c) + spin_pm((r + 1) % ROWS, c)
         + spin_pm(r, (c + COLUMNS - 1) % COLUMNS) + spin_pm(r, (c + 1) % COLUMNS);
    res.flipped = 1'b0;
    if (op.action == ACT_LOAD) begin
      ns = op.spin ? 1 : -1;
      magnet_total += ns - s;
      bond_total   += (ns - s) * nsum;
      lattice[r][c] = op.spin;
    end else begin
      de = 2 * s * nsum;
      if (de <= 0) begin
        accept = 1'b1;
      end else if (de == 4) begin
        accept = op.draw < thr_four;
      end else begin
        accept = op.draw < thr_eight;
      end
      if (accept) begin
        res.flipped   = 1'b1;
        bond_total   -= de;
        magnet_total -= 2 * s;
        lattice[r][c] = ~lattice[r][c];
      end
    end
    res.spin_after = lattice[r][c];
    res.bond       = bond_t'(bond_total);
    res.magnet     = mag_t'(magnet_total);
    return res;
  endfunction

  task automatic report(string field, int exp_val, int act_val);
    errors++;
    $display("%0t mismatch on %s: expected %0d, got %0d", $time, field, exp_val, act_val);
  endtask

  // Predict on accepted transactions, check each strobed result.
  always @(posedge clk_i) begin : result_check
    spin_result_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t result with no transaction outstanding", $time);
        end else begin
          want = pending_results.pop_front();
          if (flipped_o !== want.flipped) report("flipped", want.flipped, flipped_o);
          if (spin_after_o !== want.spin_after)
            report("spin_after", want.spin_after, spin_after_o);
          if (bond_sum_o !== want.bond) report("bond_sum", int'(want.bond), int'(bond_sum_o));
          if (magnet_sum_o !== want.magnet)
            report("magnet_sum", int'(want.magnet), int'(magnet_sum_o));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RISE_FOUR:  thr_four  = cfg_wdata_i;
          CFG_RISE_EIGHT: thr_eight = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start && busy === 1'b0) begin
        pending_results.push_back(metropolis_step(
          '{action_i, row_i, column_i, spin_value_i, random_draw_i}));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1 || cfg_we_i) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sender bursts unless steady: random run length, random gap after it.
  task automatic pace();
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        start  <= 1'b0;
        sending = 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      burst_left--;
    end
  endtask

  task automatic send_item(site_op_t op);
    start         <= 1'b1;
    sending        = 1'b1;
    action_i      <= op.action;
    row_i         <= op.row;
    column_i      <= op.column;
    spin_value_i  <= op.spin;
    random_draw_i <= op.draw;
    do @(posedge clk_i); while (busy !== 1'b0);
    pace();
  endtask

  task automatic settle();
    if (sending) begin
      start  <= 1'b0;
      sending = 1'b0;
    end
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_thresholds(thr_t four, thr_t eight);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_RISE_FOUR;
    cfg_wdata_i <= four;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RISE_EIGHT;
    cfg_wdata_i <= eight;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic site_op_t site_op(logic action, int row, int column, logic spin, int draw);
    return '{action, RowInW'(row), ColInW'(column), spin, thr_t'(draw)};
  endfunction

  // Mostly clustered sites so neighbours interact; sometimes anywhere.
  function automatic site_op_t random_site_op();
    site_op_t op;
    if ($urandom_range(0, 15) == 0) begin
      win_row = $urandom_range(0, 2**RowInW - 1);
      win_col = $urandom_range(0, 2**ColInW - 1);
    end
    op.action = ($urandom_range(0, 3) == 0) ? ACT_LOAD : ACT_ATTEMPT;
    if ($urandom_range(0, 4) < 3) begin
      op.row    = RowInW'(win_row + $urandom_range(0, 3));
      op.column = ColInW'(win_col + $urandom_range(0, 3));
    end else begin
      op.row    = RowInW'($urandom_range(0, 2**RowInW - 1));
      op.column = ColInW'($urandom_range(0, 2**ColInW - 1));
    end
    op.spin = 1'($urandom_range(0, 1));
    op.draw = ($urandom_range(0, 6) == 0) ? thr_t'($urandom_range(0, 2**ThrW - 1))
                                          : thr_t'($urandom_range(0, 9999));
    return op;
  endfunction

  // All spins up after reset, thresholds zero: only non-positive energy changes flip.
  task automatic test_cold_lattice();
    send_item(site_op(ACT_ATTEMPT, 0, 0, 1'b0, 0));
    send_item(site_op(ACT_ATTEMPT, 63, 63, 1'b1, 16383));
    send_item(site_op(ACT_LOAD, 0, 0, 1'b0, 16383));
    send_item(site_op(ACT_LOAD, 0, 0, 1'b0, 0));
    send_item(site_op(ACT_ATTEMPT, 0, 0, 1'b0, 9999));
    send_item(site_op(ACT_LOAD, 0, 1, 1'b0, 0));
    send_item(site_op(ACT_LOAD, 1, 0, 1'b0, 0));
    send_item(site_op(ACT_ATTEMPT, 0, 0, 1'b1, 0));
    send_item(site_op(ACT_LOAD, 63, 0, 1'b0, 0));
    send_item(site_op(ACT_LOAD, 0, 63, 1'b1, 0));
    settle();
  endtask

  // Draw equal to the threshold rejects, one below accepts.
  task automatic test_threshold_boundaries();
    set_thresholds(thr_t'(5000), thr_t'(10000));
    send_item(site_op(ACT_LOAD, 4, 5, 1'b0, 0));
    send_item(site_op(ACT_ATTEMPT, 5, 5, 1'b0, 5000));
    send_item(site_op(ACT_ATTEMPT, 5, 5, 1'b0, 4999));
    send_item(site_op(ACT_ATTEMPT, 5, 5, 1'b0, 0));
    send_item(site_op(ACT_ATTEMPT, 20, 20, 1'b0, 10000));
    send_item(site_op(ACT_ATTEMPT, 20, 20, 1'b0, 9999));
    send_item(site_op(ACT_ATTEMPT, 20, 20, 1'b1, 0));
    settle();
  endtask

  // Out-of-range thresholds: full scale against the widest draw, and zero.
  task automatic test_threshold_extremes();
    set_thresholds(thr_t'(2**ThrW - 1), thr_t'(0));
    send_item(site_op(ACT_ATTEMPT, 5, 5, 1'b0, 16383));
    send_item(site_op(ACT_ATTEMPT, 5, 5, 1'b0, 16382));
    send_item(site_op(ACT_ATTEMPT, 5, 5, 1'b0, 0));
    send_item(site_op(ACT_ATTEMPT, 40, 40, 1'b0, 0));
    settle();
    set_thresholds(thr_t'(0), thr_t'(2**ThrW - 1));
    send_item(site_op(ACT_ATTEMPT, 40, 40, 1'b0, 16382));
    send_item(site_op(ACT_ATTEMPT, 40, 40, 1'b0, 0));
    settle();
  endtask

  task automatic test_random_sweep();
    thr_t four, eight;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       begin four = thr_t'(1718);  eight = thr_t'(295);   end
        1:       begin four = thr_t'(10000); eight = thr_t'(10000); end
        2:       begin four = thr_t'(0);     eight = thr_t'(0);     end
        3:       begin four = '1;            eight = '1;            end
        4:       begin four = thr_t'(3679);  eight = thr_t'(1354);  end
        default: begin four = thr_t'(0);     eight = '1;            end
      endcase
      set_thresholds(four, eight);
      steady     = (phase % 3 == 2);
      burst_left = 0;
      repeat (PHASE_ITEMS) send_item(random_site_op());
      settle();
    end
  endtask

  initial begin
    foreach (lattice[r, c]) lattice[r][c] = 1'b1;
    bond_total   = 2 * ROWS * COLUMNS;
    magnet_total = ROWS * COLUMNS;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_cold_lattice();
    test_threshold_boundaries();
    test_threshold_extremes();
    test_random_sweep();
    repeat (4) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
